// ===== rtl/rsls_pkg.sv =====
// ============================================================================
// rsls_pkg
// Phase codes, error codes and tag words for the SoundFont RIFF list splitter.
// ============================================================================
package rsls_pkg;

   localparam int unsigned LEN_W   = 32;
   localparam int unsigned PHASE_W = 4;

   typedef logic [PHASE_W-1:0] phase_type;
   typedef logic [1:0]         err_type;
   typedef logic [1:0]         idx_type;
   typedef logic [LEN_W-1:0]   len_type;

   localparam phase_type PH_RIFF_ID   = 4'd0;
   localparam phase_type PH_RIFF_SIZE = 4'd1;
   localparam phase_type PH_FORM      = 4'd2;
   localparam phase_type PH_L1_ID     = 4'd3;
   localparam phase_type PH_L1_SIZE   = 4'd4;
   localparam phase_type PH_L1_DATA   = 4'd5;
   localparam phase_type PH_L2_ID     = 4'd6;
   localparam phase_type PH_L2_SIZE   = 4'd7;
   localparam phase_type PH_L2_DATA   = 4'd8;
   localparam phase_type PH_L3_ID     = 4'd9;
   localparam phase_type PH_L3_SIZE   = 4'd10;
   localparam phase_type PH_L3_DATA   = 4'd11;
   localparam phase_type PH_STOP      = 4'd12;

   localparam err_type ERR_NONE      = 2'd0;
   localparam err_type ERR_TOO_LARGE = 2'd1;
   localparam err_type ERR_TOO_SMALL = 2'd2;
   localparam err_type ERR_BROKEN    = 2'd3;

   localparam idx_type IDX_LAST = 2'd3;

   // tags packed little-endian: byte n of the tag sits at [8n +: 8]
   localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
   localparam logic [31:0] TAG_SFBK = 32'h6B62_6673;
   localparam logic [31:0] TAG_LIST = 32'h5453_494C;

   function automatic logic [7:0] tag_byte(input logic [31:0] tag, input idx_type idx);
      tag_byte = tag[{idx, 3'b000} +: 8];
   endfunction

endpackage

// ===== rtl/riff_soundfont_list_splitter.sv =====
// ============================================================================
// riff_soundfont_list_splitter
// Parses a SoundFont RIFF stream one byte per word and tags each byte with
// the LIST chunk whose payload it belongs to.
// ============================================================================
//  channel | direction | handshake            | payload
//  req     | in        | req_valid/req_stall  | start_req, data_byte
//  rsp     | out       | rsp_valid/rsp_stall  | out_byte, section, error_code, stopped
//  csr     | in        | csr_valid/csr_ready  | csr_data (total length)
//
//  One word per cycle unless stalled; a result appears in the cycle after its word.
//  Parser state and the result register update in the same cycle.
//  Reset clears parser state and the total length; csr is always ready.
//  A stalled result holds in the result register; req_stall follows
//  rsp_stall only while that register is full.
// ============================================================================
module riff_soundfont_list_splitter
   import rsls_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_start_req,
   input  logic [7:0]  req_data_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_out_byte,
   output logic [1:0]  rsp_section,
   output logic [1:0]  rsp_error_code,
   output logic        rsp_stopped,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [31:0] csr_data
);

   len_type   total_len_ff;
   phase_type phase_ff, phase_in;
   idx_type   idx_ff, idx_in;
   len_type   shift_ff, shift_in;
   len_type   buf_ff, buf_in;
   len_type   main_ff, main_in;
   len_type   pay_ff, pay_in;
   err_type   err_ff, err_in;

   logic       rsp_valid_ff;
   logic [7:0] byte_ff;
   logic [1:0] section_ff, section_in;
   err_type    err_out_ff;
   logic       stopped_ff;

   phase_type cur_phase;
   idx_type   cur_idx;
   len_type   cur_shift, cur_buf, cur_main, cur_pay;
   err_type   cur_err;
   len_type   buf_dec, main_dec, pay_dec, sh;
   logic [31:0] tag;
   logic [1:0]  list_k;
   phase_type   end_target;
   logic        accept;

   assign csr_ready = 1'b1;
   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;

   always_comb begin
      cur_phase = req_start_req ? PH_RIFF_ID : phase_ff;
      cur_idx   = req_start_req ? 2'd0 : idx_ff;
      cur_shift = req_start_req ? '0 : shift_ff;
      cur_buf   = req_start_req ? total_len_ff : buf_ff;
      cur_main  = req_start_req ? '0 : main_ff;
      cur_pay   = req_start_req ? '0 : pay_ff;
      cur_err   = req_start_req ? ERR_NONE : err_ff;

      buf_dec  = cur_buf - 1'b1;
      main_dec = cur_main - 1'b1;
      pay_dec  = (cur_pay != '0) ? cur_pay - 1'b1 : '0;
      sh       = {req_data_byte, cur_shift[31:8]};
      tag      = (cur_phase == PH_FORM) ? TAG_SFBK : TAG_LIST;

      case (cur_phase)
         PH_L1_ID, PH_L1_SIZE, PH_L1_DATA: begin
            list_k = 2'd1;
            end_target = PH_L2_ID;
         end
         PH_L2_ID, PH_L2_SIZE, PH_L2_DATA: begin
            list_k = 2'd2;
            end_target = PH_L3_ID;
         end
         default: begin
            list_k = 2'd3;
            end_target = PH_STOP;
         end
      endcase

      phase_in   = cur_phase;
      idx_in     = cur_idx;
      shift_in   = cur_shift;
      buf_in     = cur_buf;
      main_in    = cur_main;
      pay_in     = cur_pay;
      err_in     = cur_err;
      section_in = 2'd0;

      if (cur_phase < PH_STOP) begin
         if (cur_buf == '0) begin
            err_in   = ERR_BROKEN;
            phase_in = PH_STOP;
         end else begin
            buf_in = buf_dec;
            case (cur_phase)
               PH_RIFF_ID: begin
                  if (req_data_byte != tag_byte(TAG_RIFF, cur_idx)) begin
                     err_in   = ERR_BROKEN;
                     phase_in = PH_STOP;
                  end else if (cur_idx == IDX_LAST) begin
                     phase_in = PH_RIFF_SIZE;
                     idx_in   = 2'd0;
                     shift_in = '0;
                  end else begin
                     idx_in = cur_idx + 2'd1;
                     if (buf_dec == '0) begin
                        err_in   = ERR_BROKEN;
                        phase_in = PH_STOP;
                     end
                  end
               end
               PH_RIFF_SIZE: begin
                  shift_in = sh;
                  if (cur_idx == IDX_LAST) begin
                     idx_in = 2'd0;
                     if (sh < buf_dec) begin
                        err_in   = ERR_TOO_SMALL;
                        phase_in = PH_STOP;
                     end else begin
                        if (sh > buf_dec) err_in = ERR_TOO_LARGE;
                        main_in  = buf_dec;
                        phase_in = PH_FORM;
                        if (buf_dec == '0) begin
                           err_in   = ERR_BROKEN;
                           phase_in = PH_STOP;
                        end
                     end
                  end else begin
                     idx_in = cur_idx + 2'd1;
                     if (buf_dec == '0) begin
                        err_in   = ERR_BROKEN;
                        phase_in = PH_STOP;
                     end
                  end
               end
               PH_FORM, PH_L1_ID, PH_L2_ID, PH_L3_ID: begin
                  main_in = main_dec;
                  if (req_data_byte != tag_byte(tag, cur_idx)) begin
                     err_in   = ERR_BROKEN;
                     phase_in = PH_STOP;
                  end else begin
                     if (cur_idx == IDX_LAST) begin
                        phase_in = cur_phase + 4'd1;
                        idx_in   = 2'd0;
                        shift_in = '0;
                     end else begin
                        idx_in = cur_idx + 2'd1;
                     end
                     if (main_dec == '0) begin
                        err_in   = ERR_BROKEN;
                        phase_in = PH_STOP;
                     end
                  end
               end
               PH_L1_SIZE, PH_L2_SIZE, PH_L3_SIZE: begin
                  main_in  = main_dec;
                  shift_in = sh;
                  if (cur_idx == IDX_LAST) begin
                     idx_in = 2'd0;
                     if (main_dec < sh) begin
                        err_in   = ERR_BROKEN;
                        phase_in = PH_STOP;
                     end else begin
                        pay_in   = sh;
                        phase_in = cur_phase + 4'd1;
                        if (sh == '0) begin
                           phase_in = end_target;
                           if (list_k != 2'd3 && main_dec == '0) begin
                              err_in   = ERR_BROKEN;
                              phase_in = PH_STOP;
                           end
                        end
                     end
                  end else begin
                     idx_in = cur_idx + 2'd1;
                     if (main_dec == '0) begin
                        err_in   = ERR_BROKEN;
                        phase_in = PH_STOP;
                     end
                  end
               end
               default: begin
                  main_in    = main_dec;
                  section_in = list_k;
                  pay_in     = pay_dec;
                  if (pay_dec == '0) begin
                     phase_in = end_target;
                     idx_in   = 2'd0;
                     if (list_k != 2'd3 && main_dec == '0) begin
                        err_in   = ERR_BROKEN;
                        phase_in = PH_STOP;
                     end
                  end
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_len_ff <= '0;
         phase_ff     <= PH_RIFF_ID;
         idx_ff       <= 2'd0;
         shift_ff     <= '0;
         buf_ff       <= '0;
         main_ff      <= '0;
         pay_ff       <= '0;
         err_ff       <= ERR_NONE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) total_len_ff <= csr_data;
         if (accept) begin
            phase_ff <= phase_in;
            idx_ff   <= idx_in;
            shift_ff <= shift_in;
            buf_ff   <= buf_in;
            main_ff  <= main_in;
            pay_ff   <= pay_in;
            err_ff   <= err_in;
         end
         if (accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         byte_ff    <= req_data_byte;
         section_ff <= section_in;
         err_out_ff <= err_in;
         stopped_ff <= (phase_in >= PH_STOP);
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_byte   = byte_ff;
   assign rsp_section    = section_ff;
   assign rsp_error_code = err_out_ff;
   assign rsp_stopped    = stopped_ff;

endmodule

// ===== rtl/rsls_checker.sv =====
// ============================================================================
// rsls_checker
// Port-level checks for the SoundFont RIFF list splitter, bound to the top.
// ============================================================================
module rsls_checker
   import rsls_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic [7:0]  req_data_byte,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [7:0]  rsp_out_byte,
   input logic [1:0]  rsp_section,
   input logic [1:0]  rsp_error_code,
   input logic        rsp_stopped
);

   a_word_passes: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> rsp_valid && rsp_out_byte == $past(req_data_byte))
      else $error("accepted word did not reach the result register");

   a_rsp_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_byte)
         && $stable(rsp_section) && $stable(rsp_error_code))
      else $error("stalled result word changed");

   a_no_stall_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("input stalled with an empty result register");

   a_fatal_stops: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_error_code == ERR_TOO_SMALL || rsp_error_code == ERR_BROKEN)
         |-> rsp_stopped)
      else $error("fatal error without stop");

   a_payload_not_small: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_section != 2'd0 |-> rsp_error_code != ERR_TOO_SMALL)
      else $error("payload byte tagged after too-small stop");

endmodule

bind riff_soundfont_list_splitter rsls_checker u_rsls_checker (.*);

// ===== verif/testbench.sv =====
// ============================================================================
// testbench
// Drives SoundFont byte streams of varied total lengths into the list splitter,
// mostly well-formed files with random list sizes and contents, plus truncated,
// corrupted and overlong ones. A local parser model predicts every result word,
// and the monitor compares each field in order.
// ============================================================================
module testbench;
   import rsls_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;

   typedef struct packed {
      logic       start;
      logic [7:0] data;
   } byte_word_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic [1:0] section;
      err_type    err;
      logic       stopped;
   } parsed_byte_type;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_start_req = 1'b0;
   logic [7:0]  req_data_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [7:0]  rsp_out_byte;
   logic [1:0]  rsp_section;
   logic [1:0]  rsp_error_code;
   logic        rsp_stopped;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [31:0] csr_data = 32'h0;

   riff_soundfont_list_splitter dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_start_req  (req_start_req),
      .req_data_byte  (req_data_byte),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_section    (rsp_section),
      .rsp_error_code (rsp_error_code),
      .rsp_stopped    (rsp_stopped),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_data       (csr_data)
   );

   byte_word_type   words_to_send[$];
   parsed_byte_type predicted_bytes[$];
   logic [7:0]      file_image[$];

   // parser model state
   len_type   cfg_total_len = '0;
   phase_type p_phase = PH_RIFF_ID;
   idx_type   p_field_idx = '0;
   len_type   p_size_acc = '0;
   len_type   p_buf_left = '0;
   len_type   p_main_left = '0;
   len_type   p_pay_left = '0;
   err_type   p_err = ERR_NONE;

   int idle_pct = 0;
   bit quiet_tail = 1'b0;
   int gap_left = 0;
   int stall_left = 0;
   int hold_left = 0;
   bit long_hold_done = 1'b0;
   int idle_cycles = 0;
   int sent_count = 0;
   int got_count = 0;
   int fail_count = 0;
   int file_count = 0;
   int setting_count = 0;
   int err_seen[4] = '{0, 0, 0, 0};
   int list_bytes_seen = 0;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic void mark_broken();
      p_err = ERR_BROKEN;
      p_phase = PH_STOP;
   endfunction

   function automatic void close_list(input logic [3:0] list_no);
      if (list_no >= 3) begin
         p_phase = PH_STOP;
      end else begin
         p_phase = 4'(3 * (list_no + 1));
         p_field_idx = '0;
         if (p_main_left == 0) mark_broken();
      end
   endfunction

   function automatic parsed_byte_type parse_byte(input logic start, input logic [7:0] b);
      logic [1:0]      sec;
      logic [3:0]      list_no;
      logic [3:0]      sub;
      logic [31:0]     tag;
      logic [7:0]      want;
      parsed_byte_type r;
      sec = 2'd0;
      if (start) begin
         p_phase = PH_RIFF_ID;
         p_field_idx = '0;
         p_size_acc = '0;
         p_buf_left = cfg_total_len;
         p_main_left = '0;
         p_pay_left = '0;
         p_err = ERR_NONE;
      end
      if (p_phase < PH_STOP) begin
         if (p_buf_left == 0) begin
            mark_broken();
         end else begin
            p_buf_left = p_buf_left - 1;
            if (p_phase == PH_RIFF_ID) begin
               want = tag_byte(TAG_RIFF, p_field_idx);
               if (b != want) begin
                  mark_broken();
               end else if (p_field_idx == IDX_LAST) begin
                  p_phase = PH_RIFF_SIZE;
                  p_field_idx = '0;
                  p_size_acc = '0;
               end else begin
                  p_field_idx = p_field_idx + 2'd1;
                  if (p_buf_left == 0) mark_broken();
               end
            end else if (p_phase == PH_RIFF_SIZE) begin
               p_size_acc = {b, p_size_acc[31:8]};
               if (p_field_idx == IDX_LAST) begin
                  p_field_idx = '0;
                  if (p_size_acc > p_buf_left) begin
                     p_err = ERR_TOO_LARGE;
                     p_main_left = p_buf_left;
                     p_phase = PH_FORM;
                  end else if (p_size_acc < p_buf_left) begin
                     p_err = ERR_TOO_SMALL;
                     p_phase = PH_STOP;
                  end else begin
                     p_main_left = p_size_acc;
                     p_phase = PH_FORM;
                  end
                  if (p_phase == PH_FORM && p_main_left == 0) mark_broken();
               end else begin
                  p_field_idx = p_field_idx + 2'd1;
                  if (p_buf_left == 0) mark_broken();
               end
            end else begin
               p_main_left = p_main_left - 1;
               list_no = 4'(p_phase / 3);
               sub = 4'(p_phase % 3);
               if (p_phase == PH_FORM || sub == 0) begin
                  tag = (p_phase == PH_FORM) ? TAG_SFBK : TAG_LIST;
                  want = tag_byte(tag, p_field_idx);
                  if (b != want) begin
                     mark_broken();
                  end else begin
                     if (p_field_idx == IDX_LAST) begin
                        p_phase = (p_phase == PH_FORM) ? PH_L1_ID : p_phase + 4'd1;
                        p_field_idx = '0;
                        p_size_acc = '0;
                     end else begin
                        p_field_idx = p_field_idx + 2'd1;
                     end
                     if (p_main_left == 0) mark_broken();
                  end
               end else if (sub == 1) begin
                  p_size_acc = {b, p_size_acc[31:8]};
                  if (p_field_idx == IDX_LAST) begin
                     p_field_idx = '0;
                     if (p_main_left < p_size_acc) begin
                        mark_broken();
                     end else begin
                        p_pay_left = p_size_acc;
                        p_phase = p_phase + 4'd1;
                        if (p_pay_left == 0) close_list(list_no);
                     end
                  end else begin
                     p_field_idx = p_field_idx + 2'd1;
                     if (p_main_left == 0) mark_broken();
                  end
               end else begin
                  sec = list_no[1:0];
                  if (p_pay_left > 0) p_pay_left = p_pay_left - 1;
                  if (p_pay_left == 0) close_list(list_no);
               end
            end
         end
      end
      r.out_byte = b;
      r.section = sec;
      r.err = p_err;
      r.stopped = (p_phase >= PH_STOP);
      return r;
   endfunction

   // request driver
   always @(posedge clock) begin : drive_req
      logic          nxt_valid;
      byte_word_type w;
      if (reset) begin
         req_valid <= 1'b0;
         gap_left = 0;
      end else begin
         if (req_valid && !req_stall) begin
            predicted_bytes.push_back(parse_byte(req_start_req, req_data_byte));
            sent_count++;
         end
         if (!(req_valid && req_stall)) begin
            nxt_valid = 1'b0;
            if (gap_left > 0) begin
               gap_left--;
            end else if (words_to_send.size() > 0) begin
               if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
                  gap_left = $urandom_range(1, 6) - 1;
               end else begin
                  w = words_to_send.pop_front();
                  nxt_valid = 1'b1;
                  req_start_req <= w.start;
                  req_data_byte <= w.data;
               end
            end
            req_valid <= nxt_valid;
         end
      end
   end

   task automatic report_mismatch(input string what, input parsed_byte_type want);
      fail_count++;
      if (fail_count <= 10)
         $display({"mismatch on result %0d (%s): expected byte %h section %0d error %0d",
                   " stopped %0d, got byte %h section %0d error %0d stopped %0d"},
                  got_count, what, want.out_byte, want.section, want.err, want.stopped,
                  rsp_out_byte, rsp_section, rsp_error_code, rsp_stopped);
   endtask

   // result monitor and stall generator
   always @(posedge clock) begin : watch_rsp
      parsed_byte_type want;
      logic            nxt_stall;
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_left = 0;
         stall_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got_count++;
            if (predicted_bytes.size() == 0) begin
               report_mismatch("no word expected", '0);
            end else begin
               want = predicted_bytes.pop_front();
               err_seen[want.err]++;
               if (want.section != 0) list_bytes_seen++;
               if (rsp_out_byte !== want.out_byte || rsp_section !== want.section ||
                   rsp_error_code !== want.err || rsp_stopped !== want.stopped)
                  report_mismatch("field differs", want);
            end
         end
         if (!long_hold_done && !quiet_tail && got_count >= 400 &&
             words_to_send.size() > 20) begin
            long_hold_done = 1'b1;
            hold_left = 300;
         end
         if (hold_left > 0) begin
            hold_left--;
            nxt_stall = 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            nxt_stall = 1'b1;
         end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
            stall_left = $urandom_range(1, 6) - 1;
            nxt_stall = 1'b1;
         end else begin
            nxt_stall = 1'b0;
         end
         rsp_stall <= nxt_stall;
      end
   end

   always @(posedge clock) begin : watchdog
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
             (csr_valid && csr_ready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles, %0d words still expected",
                     idle_cycles, predicted_bytes.size());
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   task automatic push_byte(input logic s, input logic [7:0] d);
      words_to_send.push_back('{s, d});
   endtask

   function automatic void push_word(input logic [31:0] w);
      for (int i = 0; i < 4; i++) file_image.push_back(w[8*i +: 8]);
   endfunction

   task automatic wait_drained();
      do @(posedge clock);
      while (words_to_send.size() != 0 || req_valid || predicted_bytes.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_length(input len_type v);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_data <= v;
      do @(posedge clock);
      while (!csr_ready);
      cfg_total_len = v;
      csr_valid <= 1'b0;
      setting_count++;
   endtask

   // build one file image for a buffer of blen bytes and queue its words
   task automatic queue_file(input len_type blen, output int n_words);
      len_type     riff_len;
      len_type     room;
      len_type     sz;
      int unsigned pick;
      int unsigned n_send;
      int unsigned j;
      file_image.delete();
      riff_len = blen - 8;
      pick = $urandom_range(0, 9);
      if (pick == 0) riff_len = riff_len + $urandom_range(1, 3);
      else if (pick == 1) riff_len = riff_len - $urandom_range(1, 3);
      else if (pick == 2) riff_len = $urandom();
      push_word(TAG_RIFF);
      push_word(riff_len);
      push_word(TAG_SFBK);
      if (blen >= 1000) room = 48;
      else if (blen > 36) room = blen - 36;
      else room = 0;
      for (int k = 0; k < 3; k++) begin
         sz = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, room);
         if ($urandom_range(0, 9) == 0) sz = sz + $urandom_range(1, 8);
         room = (sz > room) ? 0 : room - sz;
         push_word(TAG_LIST);
         push_word(sz);
         repeat (sz) file_image.push_back(8'($urandom_range(0, 255)));
      end
      n_send = (blen >= 1000) ? file_image.size() + $urandom_range(0, 4) : blen;
      if ($urandom_range(0, 9) == 0) n_send += $urandom_range(1, 3);
      if (n_send == 0) n_send = 1;
      while (file_image.size() < n_send) file_image.push_back(8'($urandom_range(0, 255)));
      if ($urandom_range(0, 6) == 0) begin
         j = $urandom_range(0, n_send - 1);
         file_image[j] = file_image[j] ^ 8'($urandom_range(1, 255));
      end
      for (int i = 0; i < n_send; i++) push_byte(i == 0, file_image[i]);
      n_words = n_send;
      file_count++;
   endtask

   initial begin : sequencer
      len_type blen;
      int      n;
      int      target;
      int      n_file;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // bytes before any start, then a start into an empty buffer
      push_byte(1'b0, 8'h00);
      push_byte(1'b0, 8'hFF);
      push_byte(1'b1, 8'h52);
      wait_drained();
      // buffer ends inside the RIFF id
      write_length(3);
      push_byte(1'b1, 8'h52);
      push_byte(1'b0, 8'h49);
      push_byte(1'b0, 8'h46);
      wait_drained();
      // wrong id byte, then a byte after stop
      write_length(20);
      push_byte(1'b1, 8'h52);
      push_byte(1'b0, 8'h49);
      push_byte(1'b0, 8'h46);
      push_byte(1'b0, 8'h58);
      push_byte(1'b0, 8'hA5);
      wait_drained();

      for (int p = 0; p < 16; p++) begin
         case (p)
            0: blen = 36;
            1: blen = 0;
            2: blen = 32'hFFFF_FFFF;
            3: blen = $urandom_range(1, 12);
            4: blen = $urandom() | 32'h8000_0000;
            5: blen = $urandom_range(37, 44);
            default: blen = $urandom_range(36, 160);
         endcase
         quiet_tail = (p >= 13);
         idle_pct = (quiet_tail || p % 3 == 0) ? 0 : ((p % 3 == 1) ? 10 : 30);
         write_length(blen);
         target = (blen < 8) ? 24 : 130;
         n = 0;
         while (n < target) begin
            queue_file(blen, n_file);
            n += n_file;
         end
         wait_drained();
      end

      repeat (8) @(posedge clock);
      if (predicted_bytes.size() != 0) begin
         fail_count++;
         $display("%0d expected words never arrived", predicted_bytes.size());
      end
      $display("Parsed %0d bytes in %0d files over %0d length settings; %0d results checked.",
               sent_count, file_count, setting_count, got_count);
      $display({"Results by error: none %0d, too large %0d, too small %0d, broken %0d;",
                " list payload %0d; mismatches %0d."},
               err_seen[0], err_seen[1], err_seen[2], err_seen[3], list_bytes_seen,
               fail_count);
      if (fail_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

// ===== files.f =====
rtl/rsls_pkg.sv
rtl/riff_soundfont_list_splitter.sv
rtl/rsls_checker.sv
verif/testbench.sv
